@@ src/epaa_pkg.sv @@
`timescale 1ns / 1ps

package epaa_pkg;

    localparam int AXES       = 3;
    localparam int DIMENSIONS = 3;
    localparam int COORD_W    = 32;
    localparam int S_TDATA_W  = 296;
    localparam int M_TDATA_W  = 128;
    localparam int CFG_IDX_W  = 3;
    localparam int EXP_ORDER  = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STRENGTH = 3'd0,
        REG_DECAY    = 3'd1,
        REG_TSTEP    = 3'd2,
        REG_BOX_X    = 3'd3,
        REG_BOX_Y    = 3'd4,
        REG_BOX_Z    = 3'd5
    } reg_idx_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_EXP_MUL, OP_DIV_LD_EXP, OP_DIV_STEP, OP_EXP_UPD,
        OP_EXP_END, OP_EINV_MUL, OP_EINV_SET, OP_DIFF, OP_DIV_LD_WRAP, OP_WRAP1,
        OP_WRAP2, OP_SQ_MUL, OP_SQ_ACC, OP_SQRT_LD, OP_SQRT_STEP, OP_X_MUL,
        OP_X_SET, OP_P_ZERO, OP_P_MUL, OP_P_SET, OP_S_MUL, OP_TERM, OP_POT,
        OP_W_ABS, OP_W_LO, OP_W_HI, OP_W_Q, OP_W_SH, OP_ACC, OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
        logic [3:0] k;
        logic       sel_old;
    } cmd_t;

    typedef struct packed {
        logic       len_zero;
        logic       n_big;
        logic [4:0] n_low;
        logic       bead;
        logic       last;
    } stat_t;

endpackage

@@ src/exponential_pair_action_accumulator.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Fields (lowest bit first)
// s_       in   tdata: level, new_x/y/z, old_x/y/z, partner_x/y/z; tuser: command; tlast: last
// m_       out  tdata: action_total, potential_total; tuser: saturated
// cfg_     in   cfg_index: register, cfg_data: value
//
// One item at a time. A pair term's time is set by the shared 32-step divider (wrap
// and series), the 32-step square root and the n-fold e^-1 product; a difference
// item runs two terms, plus load, weighting and accumulation. The first item after
// reset also computes e^-1.
// Synchronous reset clears control and totals and sets the configuration registers
// to their defaults. A pending result holds m_ while the next item is taken; the block
// stalls only at emit on a full slot.

module exponential_pair_action_accumulator import epaa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // level, new_x, new_y, new_z, old_x, old_y,
                                            // old_z, partner_x, partner_y, partner_z, pad
    input  logic                 s_tuser,   // command
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // action_total, potential_total
    output logic                 m_tuser,   // saturated
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    epaa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    epaa_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ src/epaa_ctrl.sv @@
`timescale 1ns / 1ps

module epaa_ctrl import epaa_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [31:0] {
        S_IDLE     = 32'd1 << 0,
        S_EXP_MUL  = 32'd1 << 1,
        S_EXP_DLD  = 32'd1 << 2,
        S_EXP_DIV  = 32'd1 << 3,
        S_EXP_UPD  = 32'd1 << 4,
        S_EXP_END  = 32'd1 << 5,
        S_EINV_MUL = 32'd1 << 6,
        S_EINV_SET = 32'd1 << 7,
        S_DIFF     = 32'd1 << 8,
        S_WRAP_DLD = 32'd1 << 9,
        S_WRAP_DIV = 32'd1 << 10,
        S_WRAP1    = 32'd1 << 11,
        S_WRAP2    = 32'd1 << 12,
        S_SQ_MUL   = 32'd1 << 13,
        S_SQ_ACC   = 32'd1 << 14,
        S_SQRT_LD  = 32'd1 << 15,
        S_SQRT     = 32'd1 << 16,
        S_X_MUL    = 32'd1 << 17,
        S_X_SET    = 32'd1 << 18,
        S_X_CHK    = 32'd1 << 19,
        S_P_MUL    = 32'd1 << 20,
        S_P_SET    = 32'd1 << 21,
        S_S_MUL    = 32'd1 << 22,
        S_TERM     = 32'd1 << 23,
        S_POT      = 32'd1 << 24,
        S_W_ABS    = 32'd1 << 25,
        S_W_LO     = 32'd1 << 26,
        S_W_HI     = 32'd1 << 27,
        S_W_Q      = 32'd1 << 28,
        S_W_SH     = 32'd1 << 29,
        S_ACC      = 32'd1 << 30,
        S_OUT      = 32'd1 << 31
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] k_reg, k_next;
    logic       sel_old_reg, sel_old_next;
    logic       einv_ok_reg, einv_ok_next;
    logic       mvalid_reg, mvalid_next;
    op_t        op;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign cmd      = '{op: op, axis: axis_reg, k: k_reg, sel_old: sel_old_reg};

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        sel_old_next = sel_old_reg;
        einv_ok_next = einv_ok_reg;
        mvalid_next  = mvalid_reg & ~m_tready;
        op           = OP_NOP;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op           = OP_LOAD;
                    k_next       = 4'd1;
                    axis_next    = 2'd0;
                    sel_old_next = 1'b0;
                    state_next   = einv_ok_reg ? S_DIFF : S_EXP_MUL;
                end
            end
            S_EXP_MUL: begin
                op         = OP_EXP_MUL;
                state_next = S_EXP_DLD;
            end
            S_EXP_DLD: begin
                op         = OP_DIV_LD_EXP;
                cnt_next   = 5'd0;
                state_next = S_EXP_DIV;
            end
            S_EXP_DIV: begin
                op       = OP_DIV_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = S_EXP_UPD;
                end
            end
            S_EXP_UPD: begin
                op = OP_EXP_UPD;
                if (k_reg == 4'(EXP_ORDER)) begin
                    state_next = S_EXP_END;
                end else begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_EXP_MUL;
                end
            end
            S_EXP_END: begin
                op       = OP_EXP_END;
                cnt_next = 5'd0;
                if (!einv_ok_reg) begin
                    state_next = S_EINV_MUL;
                end else if (stat.n_low == 5'd0) begin
                    state_next = S_S_MUL;
                end else begin
                    state_next = S_P_MUL;
                end
            end
            S_EINV_MUL: begin
                op         = OP_EINV_MUL;
                state_next = S_EINV_SET;
            end
            S_EINV_SET: begin
                op           = OP_EINV_SET;
                einv_ok_next = 1'b1;
                axis_next    = 2'd0;
                sel_old_next = 1'b0;
                state_next   = S_DIFF;
            end
            S_DIFF: begin
                op         = OP_DIFF;
                state_next = stat.len_zero ? S_WRAP1 : S_WRAP_DLD;
            end
            S_WRAP_DLD: begin
                op         = OP_DIV_LD_WRAP;
                cnt_next   = 5'd0;
                state_next = S_WRAP_DIV;
            end
            S_WRAP_DIV: begin
                op       = OP_DIV_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = S_WRAP1;
                end
            end
            S_WRAP1: begin
                op         = OP_WRAP1;
                state_next = S_WRAP2;
            end
            S_WRAP2: begin
                op         = OP_WRAP2;
                state_next = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                op         = OP_SQ_MUL;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                op = OP_SQ_ACC;
                if (axis_reg == 2'(DIMENSIONS - 1)) begin
                    state_next = S_SQRT_LD;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_DIFF;
                end
            end
            S_SQRT_LD: begin
                op         = OP_SQRT_LD;
                cnt_next   = 5'd0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                op       = OP_SQRT_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = S_X_MUL;
                end
            end
            S_X_MUL: begin
                op         = OP_X_MUL;
                state_next = S_X_SET;
            end
            S_X_SET: begin
                op         = OP_X_SET;
                k_next     = 4'd1;
                state_next = S_X_CHK;
            end
            S_X_CHK: begin
                if (stat.n_big) begin
                    op         = OP_P_ZERO;
                    state_next = S_S_MUL;
                end else begin
                    state_next = S_EXP_MUL;
                end
            end
            S_P_MUL: begin
                op         = OP_P_MUL;
                state_next = S_P_SET;
            end
            S_P_SET: begin
                op       = OP_P_SET;
                cnt_next = cnt_reg + 5'd1;
                state_next = (5'(cnt_reg + 5'd1) == stat.n_low) ? S_S_MUL : S_P_MUL;
            end
            S_S_MUL: begin
                op         = OP_S_MUL;
                state_next = S_TERM;
            end
            S_TERM: begin
                op = OP_TERM;
                if (!sel_old_reg && !stat.bead) begin
                    sel_old_next = 1'b1;
                    axis_next    = 2'd0;
                    state_next   = S_DIFF;
                end else begin
                    state_next = S_POT;
                end
            end
            S_POT: begin
                op         = OP_POT;
                state_next = S_W_ABS;
            end
            S_W_ABS: begin
                op         = OP_W_ABS;
                state_next = S_W_LO;
            end
            S_W_LO: begin
                op         = OP_W_LO;
                state_next = S_W_HI;
            end
            S_W_HI: begin
                op         = OP_W_HI;
                state_next = S_W_Q;
            end
            S_W_Q: begin
                op         = OP_W_Q;
                state_next = S_W_SH;
            end
            S_W_SH: begin
                op         = OP_W_SH;
                state_next = S_ACC;
            end
            S_ACC: begin
                op         = OP_ACC;
                state_next = stat.last ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    op          = OP_OUT;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            axis_reg    <= 2'd0;
            cnt_reg     <= 5'd0;
            k_reg       <= 4'd1;
            sel_old_reg <= 1'b0;
            einv_ok_reg <= 1'b0;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            sel_old_reg <= sel_old_next;
            einv_ok_reg <= einv_ok_next;
            mvalid_reg  <= mvalid_next;
        end
    end

endmodule

@@ src/epaa_dpath.sv @@
`timescale 1ns / 1ps

module epaa_dpath import epaa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser
);

    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;

    logic [31:0] strength_reg, decay_reg, tstep_reg;
    logic [31:0] box_reg [AXES];

    logic        bead_reg, last_reg;
    logic [3:0]  level_reg;
    logic [31:0] new_reg [AXES];
    logic [31:0] old_reg [AXES];
    logic [31:0] part_reg [AXES];

    logic [65:0] prod_reg;
    logic [32:0] diff_reg;
    logic [31:0] rem_reg, dq_reg, dv_reg;
    logic [31:0] r_reg, m_reg;
    logic [63:0] sq_reg, sx_reg, sres_reg, sbit_reg;
    logic [31:0] n_reg, f_reg;
    logic [32:0] t_reg, p_reg, einv_reg;
    logic signed [34:0] esum_reg;
    logic [48:0] vnew_reg, vold_reg;
    logic [49:0] pot_reg, wmag_reg;
    logic        wneg_reg, wsat_reg;
    logic [3:0]  wlvl_reg;
    logic [63:0] pl_reg, wq_reg, act_reg;
    logic [63:0] asum_reg, psum_reg;
    logic        flag_reg;
    logic [63:0] mact_reg, mpot_reg;
    logic        msat_reg;

    logic [31:0] len, sabs, absd, a_coord, r1, m1;
    logic [32:0] mul_a, mul_b, trial, trial_sub;
    logic        mul_en, ge;
    logic [65:0] prod_next;
    logic [64:0] sq_sum;
    logic [63:0] sq_base, strial, lim, sh;
    logic [66:0] qsum;
    logic [47:0] tmag;
    logic [48:0] term;
    logic [64:0] a_add, p_add;
    logic [34:0] ext_dq;

    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return {1'b1, (s[64] ? INT64_MIN : INT64_MAX)};
        end
        return {1'b0, s[63:0]};
    endfunction

    assign len  = box_reg[cmd.axis];
    assign sabs = strength_reg[31] ? (~strength_reg + 32'd1) : strength_reg;
    assign absd = diff_reg[32] ? 32'(~diff_reg + 33'd1) : diff_reg[31:0];
    assign a_coord = cmd.sel_old ? old_reg[cmd.axis] : new_reg[cmd.axis];

    assign stat = '{len_zero: (len == 32'd0), n_big: (|n_reg[31:5]), n_low: n_reg[4:0],
                    bead: bead_reg, last: last_reg};

    assign m_tdata = {mpot_reg, mact_reg};
    assign m_tuser = msat_reg;

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd.op)
            OP_SQ_MUL: begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            OP_X_MUL: begin
                mul_a = {1'b0, decay_reg};
                mul_b = {1'b0, sres_reg[31:0]};
            end
            OP_EXP_MUL: begin
                mul_a = t_reg;
                mul_b = {1'b0, f_reg};
            end
            OP_EINV_MUL: begin
                mul_a = p_reg;
                mul_b = p_reg;
            end
            OP_P_MUL: begin
                mul_a = p_reg;
                mul_b = einv_reg;
            end
            OP_S_MUL: begin
                mul_a = {1'b0, sabs};
                mul_b = p_reg;
            end
            OP_W_LO: begin
                mul_a = {1'b0, wmag_reg[31:0]};
                mul_b = {1'b0, tstep_reg};
            end
            OP_W_HI: begin
                mul_a = {15'd0, wmag_reg[49:32]};
                mul_b = {1'b0, tstep_reg};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
        prod_next = 66'(mul_a) * 66'(mul_b);
    end

    always_comb begin
        trial     = {rem_reg, dq_reg[31]};
        ge        = (trial >= {1'b0, dv_reg});
        trial_sub = trial - {1'b0, dv_reg};
        if (len == 32'd0) begin
            r1 = absd;
        end else if (diff_reg[32] && (rem_reg != 32'd0)) begin
            r1 = len - rem_reg;
        end else begin
            r1 = rem_reg;
        end
        if (len == 32'd0) begin
            m1 = r_reg;
        end else if ({r_reg, 1'b0} >= {1'b0, len}) begin
            m1 = len - r_reg;
        end else begin
            m1 = r_reg;
        end
        sq_base = (cmd.axis == 2'd0) ? 64'd0 : sq_reg;
        sq_sum  = {1'b0, sq_base} + {1'b0, prod_reg[63:0]};
        strial  = sres_reg + sbit_reg;
        ext_dq  = {3'd0, dq_reg};
        tmag    = prod_reg[63:16];
        term    = strength_reg[31] ? (~{1'b0, tmag} + 49'd1) : {1'b0, tmag};
        qsum    = {1'b0, prod_reg[49:0], 16'd0} + {19'd0, pl_reg[63:16]};
        lim     = (wneg_reg ? INT64_MIN : INT64_MAX) >> wlvl_reg;
        sh      = wq_reg << wlvl_reg;
        a_add   = sat_add(asum_reg, act_reg);
        p_add   = sat_add(psum_reg, {{14{pot_reg[49]}}, pot_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strength_reg <= 32'd0;
            decay_reg    <= 32'd65536;
            tstep_reg    <= 32'd65536;
            for (int i = 0; i < AXES; i++) begin
                box_reg[i] <= 32'hFFFF_FFFF;
            end
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STRENGTH: strength_reg <= cfg_data;
                REG_DECAY:    decay_reg    <= cfg_data;
                REG_TSTEP:    tstep_reg    <= cfg_data;
                REG_BOX_X:    box_reg[0]   <= cfg_data;
                REG_BOX_Y:    box_reg[1]   <= cfg_data;
                REG_BOX_Z:    box_reg[2]   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asum_reg <= 64'd0;
            psum_reg <= 64'd0;
            flag_reg <= 1'b0;
        end else if (cmd.op == OP_ACC) begin
            asum_reg <= a_add[63:0];
            psum_reg <= p_add[63:0];
            flag_reg <= flag_reg | wsat_reg | a_add[64] | p_add[64];
        end else if (cmd.op == OP_OUT) begin
            asum_reg <= 64'd0;
            psum_reg <= 64'd0;
            flag_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
        unique case (cmd.op)
            OP_LOAD: begin
                bead_reg  <= s_tuser;
                last_reg  <= s_tlast;
                level_reg <= s_tdata[3:0];
                for (int i = 0; i < AXES; i++) begin
                    new_reg[i]  <= s_tdata[4 + COORD_W * i +: COORD_W];
                    old_reg[i]  <= s_tdata[4 + COORD_W * (AXES + i) +: COORD_W];
                    part_reg[i] <= s_tdata[4 + COORD_W * (2 * AXES + i) +: COORD_W];
                end
                f_reg    <= 32'h8000_0000;
                t_reg    <= ONE_Q32;
                esum_reg <= $signed({2'd0, ONE_Q32});
            end
            OP_DIV_LD_EXP: begin
                rem_reg <= 32'd0;
                dq_reg  <= prod_reg[63:32];
                dv_reg  <= {28'd0, cmd.k};
            end
            OP_DIV_LD_WRAP: begin
                rem_reg <= 32'd0;
                dq_reg  <= absd;
                dv_reg  <= len;
            end
            OP_DIV_STEP: begin
                rem_reg <= ge ? trial_sub[31:0] : trial[31:0];
                dq_reg  <= {dq_reg[30:0], ge};
            end
            OP_EXP_UPD: begin
                t_reg    <= {1'b0, dq_reg};
                esum_reg <= cmd.k[0] ? (esum_reg - $signed(ext_dq))
                                     : (esum_reg + $signed(ext_dq));
            end
            OP_EXP_END: begin
                if (esum_reg < 0) begin
                    p_reg <= 33'd0;
                end else if (esum_reg > $signed({2'd0, ONE_Q32})) begin
                    p_reg <= ONE_Q32;
                end else begin
                    p_reg <= esum_reg[32:0];
                end
            end
            OP_EINV_SET: einv_reg <= prod_reg[64:32];
            OP_DIFF: begin
                diff_reg <= {a_coord[31], a_coord}
                          - {part_reg[cmd.axis][31], part_reg[cmd.axis]};
            end
            OP_WRAP1:  r_reg <= r1;
            OP_WRAP2:  m_reg <= m1;
            OP_SQ_ACC: sq_reg <= sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_sum[63:0];
            OP_SQRT_LD: begin
                sx_reg   <= sq_reg;
                sres_reg <= 64'd0;
                sbit_reg <= 64'd1 << 62;
            end
            OP_SQRT_STEP: begin
                if (sx_reg >= strial) begin
                    sx_reg   <= sx_reg - strial;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end else begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            OP_X_SET: begin
                n_reg    <= prod_reg[63:32];
                f_reg    <= prod_reg[31:0];
                t_reg    <= ONE_Q32;
                esum_reg <= $signed({2'd0, ONE_Q32});
            end
            OP_P_ZERO: p_reg <= 33'd0;
            OP_P_SET:  p_reg <= prod_reg[64:32];
            OP_TERM: begin
                if (cmd.sel_old) begin
                    vold_reg <= term;
                end else begin
                    vnew_reg <= term;
                end
            end
            OP_POT: begin
                pot_reg <= bead_reg ? {vnew_reg[48], vnew_reg}
                                    : ({vnew_reg[48], vnew_reg} - {vold_reg[48], vold_reg});
            end
            OP_W_ABS: begin
                wneg_reg <= pot_reg[49];
                wmag_reg <= pot_reg[49] ? (~pot_reg + 50'd1) : pot_reg;
                wlvl_reg <= bead_reg ? 4'd0 : level_reg;
            end
            OP_W_HI: pl_reg <= prod_reg[63:0];
            OP_W_Q: begin
                wsat_reg <= (|prod_reg[49:47]) || (qsum > {3'd0, lim});
                wq_reg   <= qsum[63:0];
            end
            OP_W_SH: begin
                if (wsat_reg) begin
                    act_reg <= wneg_reg ? INT64_MIN : INT64_MAX;
                end else begin
                    act_reg <= wneg_reg ? (~sh + 64'd1) : sh;
                end
            end
            OP_OUT: begin
                mact_reg <= asum_reg;
                mpot_reg <= psum_reg;
                msat_reg <= flag_reg;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ tb/action_checker.sv @@
`timescale 1ns / 1ps

module action_checker import epaa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   errors,
    output int                   n_pending
);

    localparam longint     INT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint     INT_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [63:0] ONE    = 64'h1_0000_0000;
    localparam logic [63:0] LO32   = 64'hFFFF_FFFF;

    typedef struct {
        logic [63:0] action;
        logic [63:0] potential;
        logic        saturated;
    } totals_t;

    totals_t     expected_totals[$];

    longint      v0;
    logic [31:0] alpha;
    logic [31:0] tau;
    logic [31:0] box [3];
    longint      action_acc;
    longint      potential_acc;
    logic        clipped;

    function automatic longint sat_sum(longint a, longint b);
        if (b > 0 && a > INT_MAX - b) begin
            clipped = 1'b1;
            return INT_MAX;
        end
        if (b < 0 && a < INT_MIN - b) begin
            clipped = 1'b1;
            return INT_MIN;
        end
        return a + b;
    endfunction

    function automatic longint min_image(longint d, logic [31:0] len);
        longint l;
        longint r;
        l = longint'({32'b0, len});
        if (len == 0) return d;
        r = d % l;
        if (r < 0) r += l;
        if (2 * r >= l) r -= l;
        return r;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'h1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] exp_neg_frac(logic [63:0] f);
        logic [63:0] t;
        longint      s;
        t = ONE;
        s = longint'(ONE);
        for (int k = 1; k <= EXP_ORDER; k++) begin
            t = ((t * f) >> 32) / k;
            if (k % 2 == 1) s -= longint'(t);
            else s += longint'(t);
        end
        if (s < 0) s = 0;
        if (s > longint'(ONE)) s = longint'(ONE);
        return 64'(s);
    endfunction

    function automatic longint pair_energy(longint a [3], longint b [3]);
        logic [63:0] sq;
        logic [63:0] m;
        logic [63:0] s;
        logic [63:0] x;
        logic [63:0] p;
        logic [63:0] h;
        logic [63:0] einv;
        logic [63:0] n;
        logic [63:0] mag;
        longint      w;
        sq = 0;
        for (int d = 0; d < DIMENSIONS && d < 3; d++) begin
            w = min_image(a[d] - b[d], box[d]);
            m = 64'(w < 0 ? -w : w);
            s = m * m;
            sq = (sq > ~64'h0 - s) ? ~64'h0 : sq + s;
        end
        x = {32'b0, alpha} * root64(sq);
        n = x >> 32;
        p = exp_neg_frac(x & LO32);
        if (n >= 32) begin
            p = 0;
        end else begin
            h = exp_neg_frac(ONE >> 1);
            einv = (h * h) >> 32;
            for (int i = 0; i < int'(n); i++) p = (p * einv) >> 32;
        end
        mag = (64'(v0 < 0 ? -v0 : v0) * p) >> 16;
        return v0 < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint scale_by_tau(longint v, logic [3:0] lvl);
        logic        neg;
        logic        sat;
        logic [63:0] mag;
        logic [63:0] lim;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] q;
        logic [63:0] lo;
        neg = v < 0;
        mag = 64'(neg ? -v : v);
        lim = neg ? (64'h1 << 63) : 64'h7FFF_FFFF_FFFF_FFFF;
        a = (mag >> 32) * {32'b0, tau};
        b = (mag & LO32) * {32'b0, tau};
        sat = 1'b0;
        q = 0;
        if (a >= (64'h1 << 47)) begin
            sat = 1'b1;
        end else begin
            q = a << 16;
            lo = b >> 16;
            if (q > ~64'h0 - lo) begin
                sat = 1'b1;
            end else begin
                q = q + lo;
                if (q > (lim >> lvl)) sat = 1'b1;
                else q = q << lvl;
            end
        end
        if (sat) begin
            clipped = 1'b1;
            return neg ? INT_MIN : INT_MAX;
        end
        if (neg) return (q == (64'h1 << 63)) ? INT_MIN : -longint'(q);
        return longint'(q);
    endfunction

    task automatic predict_beat();
        longint  nw [3];
        longint  od [3];
        longint  pt [3];
        longint  vnew;
        longint  pot;
        longint  act;
        totals_t t;
        for (int d = 0; d < 3; d++) begin
            nw[d] = longint'($signed(s_tdata[4 + 32 * d +: 32]));
            od[d] = longint'($signed(s_tdata[100 + 32 * d +: 32]));
            pt[d] = longint'($signed(s_tdata[196 + 32 * d +: 32]));
        end
        vnew = pair_energy(nw, pt);
        if (s_tuser) begin
            pot = vnew;
            act = scale_by_tau(vnew, 4'd0);
        end else begin
            pot = vnew - pair_energy(od, pt);
            act = scale_by_tau(pot, s_tdata[3:0]);
        end
        action_acc = sat_sum(action_acc, act);
        potential_acc = sat_sum(potential_acc, pot);
        if (s_tlast) begin
            t.action = action_acc;
            t.potential = potential_acc;
            t.saturated = clipped;
            expected_totals.push_back(t);
            action_acc = 0;
            potential_acc = 0;
            clipped = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        totals_t t;
        if (!aresetn) begin
            v0 = 0;
            alpha = 32'h0001_0000;
            tau = 32'h0001_0000;
            box[0] = 32'hFFFF_FFFF;
            box[1] = 32'hFFFF_FFFF;
            box[2] = 32'hFFFF_FFFF;
            action_acc = 0;
            potential_acc = 0;
            clipped = 1'b0;
            expected_totals.delete();
            n_pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_totals.size() == 0) begin
                    $error("unexpected result beat");
                    errors++;
                end else begin
                    t = expected_totals.pop_front();
                    if (m_tdata[63:0] !== t.action) begin
                        $error("action_total expected %0d got %0d",
                               $signed(t.action), $signed(m_tdata[63:0]));
                        errors++;
                    end
                    if (m_tdata[127:64] !== t.potential) begin
                        $error("potential_total expected %0d got %0d",
                               $signed(t.potential), $signed(m_tdata[127:64]));
                        errors++;
                    end
                    if (m_tuser !== t.saturated) begin
                        $error("saturated expected %0d got %0d", t.saturated, m_tuser);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_beat();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_STRENGTH: v0 = longint'($signed(cfg_data));
                    REG_DECAY:    alpha = cfg_data;
                    REG_TSTEP:    tau = cfg_data;
                    REG_BOX_X:    box[0] = cfg_data;
                    REG_BOX_Y:    box[1] = cfg_data;
                    REG_BOX_Z:    box[2] = cfg_data;
                    default: ;
                endcase
            end
            n_pending <= expected_totals.size();
        end
    end

    initial errors = 0;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import epaa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [31:0]          Q_ONE     = 32'h0001_0000;
    localparam int                   N_RANDOM  = 830;
    localparam int                   DRAIN     = 3000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    int                   errors;
    int                   n_pending;

    int                   s_idle_pct = 0;
    int                   m_idle_pct = 0;
    int                   hold_reqs = 0;
    int                   hold_seen;
    int                   hold_left;
    int                   sent = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    exponential_pair_action_accumulator u_dut (.*);

    action_checker u_checker (.*);

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= 12000;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    task automatic send_pair(logic cmd, logic [3:0] lvl, logic [31:0] c [9], logic lst);
        logic [S_TDATA_W-1:0] d;
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        d = '0;
        d[3:0] = lvl;
        for (int i = 0; i < 9; i++) d[4 + 32 * i +: 32] = c[i];
        s_tdata <= d;
        s_tuser <= cmd;
        s_tlast <= lst;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (n_pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic load_settings(logic [31:0] s, logic [31:0] a, logic [31:0] t,
                                 logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
        write_reg(REG_STRENGTH, s);
        write_reg(REG_DECAY, a);
        write_reg(REG_TSTEP, t);
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        write_reg(REG_BOX_Z, bz);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_box();
        case ($urandom_range(3))
            0: return 32'h0;
            1: return $urandom_range(8 * Q_ONE, 1);
            2: return $urandom();
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic random_pair(logic lst);
        logic [31:0] c [9];
        logic [31:0] base;
        base = $urandom();
        for (int i = 0; i < 9; i++) begin
            if ($urandom_range(9) == 0) c[i] = $urandom();
            else c[i] = base + $urandom_range(6 * Q_ONE) - 3 * Q_ONE;
            if (i % 3 == 2) base = $urandom();
        end
        for (int i = 0; i < 3; i++) if ($urandom_range(7) == 0) c[6 + i] = c[i];
        send_pair(1'($urandom_range(1)), 4'($urandom_range(15)), c, lst);
    endtask

    task automatic directed_pair(logic cmd, logic [3:0] lvl, logic [31:0] nw,
                                 logic [31:0] od, logic [31:0] pt, logic lst);
        logic [31:0] c [9];
        for (int i = 0; i < 3; i++) begin
            c[i] = nw;
            c[3 + i] = od;
            c[6 + i] = pt;
        end
        send_pair(cmd, lvl, c, lst);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_settings(Q_ONE, Q_ONE, Q_ONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed_pair(1'b0, 4'd0, 32'h0, 32'h0, 32'h0, 1'b1);
        directed_pair(1'b1, 4'd0, 32'h0, 32'h8000_0000, 32'h0, 1'b1);
        directed_pair(1'b0, 4'd15, 32'h0, Q_ONE, 32'h0, 1'b0);
        directed_pair(1'b0, 4'd15, 32'h8000, 32'h4_0000, 32'h0, 1'b1);
        directed_pair(1'b1, 4'd7, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b1);
        directed_pair(1'b0, 4'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 1'b1);
        directed_pair(1'b0, 4'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b0);
        directed_pair(1'b1, 4'd15, 32'h0002_0000, 32'hFFFF_FFFF, 32'h0, 1'b1);
        drain();
        load_settings(32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed_pair(1'b1, 4'd0, 32'h0, 32'h0, Q_ONE, 1'b0);
        directed_pair(1'b1, 4'd0, 32'h0, 32'h0, Q_ONE, 1'b1);
        directed_pair(1'b0, 4'd15, 32'h0, 32'h0, Q_ONE, 1'b1);
        drain();
        load_settings(32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h1, 32'h1);
        directed_pair(1'b0, 4'd15, 32'h1234_5678, 32'h0, 32'h8765_4321, 1'b1);
        directed_pair(1'b1, 4'd2, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b1);
        drain();
        load_settings(32'h8000_0000, Q_ONE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        directed_pair(1'b0, 4'd15, 32'h0, 32'h0001_8000, 32'h0, 1'b0);
        directed_pair(1'b1, 4'd0, 32'h0, 32'h0, 32'h0, 1'b0);
        directed_pair(1'b1, 4'd0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b1);
        drain();
        write_reg(REG_SPARE, 32'hDEAD_BEEF);
        cfg_valid <= 1'b0;

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            if (ph == 0)
                load_settings(Q_ONE, Q_ONE, Q_ONE, 4 * Q_ONE, 32'h0, 32'hFFFF_FFFF);
            else
                load_settings(($urandom_range(3) == 0) ? $urandom() : $urandom_range(4 * Q_ONE),
                              $urandom_range(3 * Q_ONE), $urandom_range(4 * Q_ONE),
                              pick_box(), pick_box(), pick_box());
            if (ph == 2) begin
                hold_reqs <= hold_reqs + 1;
                for (int i = 0; i < 8; i++) random_pair(1'b1);
                drain();
            end
            for (int i = 0; i < N_RANDOM / 8; i++) begin
                if (sent < 290) begin
                    s_idle_pct = 6;
                    m_idle_pct <= 56;
                end else if (sent < 580) begin
                    s_idle_pct = 56;
                    m_idle_pct <= 6;
                end else begin
                    s_idle_pct = 0;
                    m_idle_pct <= 0;
                end
                random_pair($urandom_range(7) == 0);
            end
        end
        drain();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
